// File: rtl/irfd_pkg.sv
`default_nettype none

package irfd_pkg;

    localparam int unsigned TICK_W        = 15;
    localparam int unsigned TOL_W         = 7;
    localparam int unsigned LIMIT_W       = 22;
    localparam int unsigned CFG_INDEX_W   = 3;
    localparam int unsigned COUNT_W       = 8;
    localparam int unsigned BYTE_IDX_W    = 5;
    localparam int unsigned WORD_BYTES    = 4;
    localparam int unsigned CMD_BYTE_IDX  = 5;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam int unsigned FRAME_BYTES_DEFAULT = 19;

    localparam int unsigned HEADER_MARK_RST  = 3400;
    localparam int unsigned HEADER_SPACE_RST = 1750;
    localparam int unsigned BIT_MARK_RST     = 450;
    localparam int unsigned ONE_SPACE_RST    = 1300;
    localparam int unsigned ZERO_SPACE_RST   = 420;
    localparam int unsigned TOL_RST          = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE    = 3'd5;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BAD_HEADER = 3'd1,
        STATUS_BAD_MARK   = 3'd2,
        STATUS_BAD_SPACE  = 3'd3,
        STATUS_SHORT      = 3'd4
    } status_t;

    typedef struct packed {
        logic frame_start;
        logic frame_end;
        logic header_ok;
        logic bit_mark_ok;
        logic one_ok;
        logic zero_ok;
    } symbol_class_t;

endpackage

`default_nettype wire

// File: rtl/irfd_front.sv
`default_nettype none

module irfd_front
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [irfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [irfd_pkg::TICK_W-1:0]          cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [irfd_pkg::TICK_W-1:0]          mark_ticks,
    input  wire logic [irfd_pkg::TICK_W-1:0]          space_ticks,
    input  wire logic                                 frame_start,
    input  wire logic                                 frame_end,
    input  wire logic                                 q_ready,
    output logic                                      q_push,
    output irfd_pkg::symbol_class_t                   q_data
);
    import irfd_pkg::*;

    logic [TICK_W-1:0]  hdr_mark_reg, hdr_space_reg, bit_mark_reg, one_space_reg, zero_space_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [LIMIT_W-1:0] hdr_mark_lim_reg, hdr_space_lim_reg, bit_mark_lim_reg;
    logic [LIMIT_W-1:0] one_space_lim_reg, zero_space_lim_reg;

    logic               stage_valid_reg, stage_valid_next;
    logic [TICK_W-1:0]  stage_mark_reg, stage_space_reg;
    logic               stage_start_reg, stage_end_reg;
    logic               accept;

    function automatic logic near(input logic [TICK_W-1:0] got,
                                  input logic [TICK_W-1:0] want,
                                  input logic [LIMIT_W-1:0] limit);
        logic [TICK_W-1:0]  diff;
        logic [LIMIT_W-1:0] scaled;
        diff   = (got >= want) ? (got - want) : (want - got);
        scaled = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
        return scaled <= limit;
    endfunction

    function automatic logic [LIMIT_W-1:0] limit_of(input logic [TICK_W-1:0] want,
                                                    input logic [TOL_W-1:0] tol);
        return LIMIT_W'({{(LIMIT_W-TICK_W){1'b0}}, want} * {{(LIMIT_W-TOL_W){1'b0}}, tol});
    endfunction

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_mark_reg   <= TICK_W'(HEADER_MARK_RST);
            hdr_space_reg  <= TICK_W'(HEADER_SPACE_RST);
            bit_mark_reg   <= TICK_W'(BIT_MARK_RST);
            one_space_reg  <= TICK_W'(ONE_SPACE_RST);
            zero_space_reg <= TICK_W'(ZERO_SPACE_RST);
            tol_reg        <= TOL_W'(TOL_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER_MARK:  hdr_mark_reg   <= cfg_data;
                REG_HEADER_SPACE: hdr_space_reg  <= cfg_data;
                REG_BIT_MARK:     bit_mark_reg   <= cfg_data;
                REG_ONE_SPACE:    one_space_reg  <= cfg_data;
                REG_ZERO_SPACE:   zero_space_reg <= cfg_data;
                REG_TOLERANCE:    tol_reg        <= cfg_data[TOL_W-1:0];
                default:          ;
            endcase
        end
    end

    // tolerance windows, one product per expected duration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_mark_lim_reg   <= LIMIT_W'(HEADER_MARK_RST * TOL_RST);
            hdr_space_lim_reg  <= LIMIT_W'(HEADER_SPACE_RST * TOL_RST);
            bit_mark_lim_reg   <= LIMIT_W'(BIT_MARK_RST * TOL_RST);
            one_space_lim_reg  <= LIMIT_W'(ONE_SPACE_RST * TOL_RST);
            zero_space_lim_reg <= LIMIT_W'(ZERO_SPACE_RST * TOL_RST);
        end
        else
        begin
            hdr_mark_lim_reg   <= limit_of(hdr_mark_reg, tol_reg);
            hdr_space_lim_reg  <= limit_of(hdr_space_reg, tol_reg);
            bit_mark_lim_reg   <= limit_of(bit_mark_reg, tol_reg);
            one_space_lim_reg  <= limit_of(one_space_reg, tol_reg);
            zero_space_lim_reg <= limit_of(zero_space_reg, tol_reg);
        end
    end

    // input stage
    assign in_stall = stage_valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;
    assign q_push   = stage_valid_reg && q_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_mark_reg  <= mark_ticks;
            stage_space_reg <= space_ticks;
            stage_start_reg <= frame_start;
            stage_end_reg   <= frame_end;
        end
    end

    // classify the held word
    always_comb
    begin
        q_data.frame_start = stage_start_reg;
        q_data.frame_end   = stage_end_reg;
        q_data.header_ok   = near(stage_mark_reg, hdr_mark_reg, hdr_mark_lim_reg)
                          && near(stage_space_reg, hdr_space_reg, hdr_space_lim_reg);
        q_data.bit_mark_ok = near(stage_mark_reg, bit_mark_reg, bit_mark_lim_reg);
        q_data.one_ok      = near(stage_space_reg, one_space_reg, one_space_lim_reg);
        q_data.zero_ok     = near(stage_space_reg, zero_space_reg, zero_space_lim_reg);
    end

endmodule

`default_nettype wire

// File: rtl/irfd_queue.sv
`default_nettype none

module irfd_queue
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire irfd_pkg::symbol_class_t    push_data,
    output logic                            push_ready,
    input  wire logic                       pop,
    output logic                            pop_valid,
    output irfd_pkg::symbol_class_t         pop_data
);
    import irfd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    symbol_class_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg < CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/irfd_back.sv
`default_nettype none

module irfd_back
#(
    parameter int unsigned FRAME_BYTES = irfd_pkg::FRAME_BYTES_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire irfd_pkg::symbol_class_t    q_data,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output irfd_pkg::status_t               status,
    output logic [7:0]                      command_byte,
    output logic [31:0]                     first_word,
    output logic                            checksum_ok
);
    import irfd_pkg::*;

    localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_BYTES - 1);
    localparam logic [BYTE_IDX_W-1:0] CMD_IDX  = BYTE_IDX_W'(CMD_BYTE_IDX);
    localparam logic [BYTE_IDX_W-1:0] WORD_END = BYTE_IDX_W'(WORD_BYTES);

    logic                   active_reg, active_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [7:0]             shift_reg, shift_next;
    logic [7:0]             sum_reg, sum_next;
    logic [31:0]            word_reg, word_next;
    logic [7:0]             cmd_reg, cmd_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg;
    logic [7:0]             cmd_out_reg;
    logic [31:0]            word_out_reg;
    logic                   ok_out_reg;

    logic                   emit;
    status_t                res_status;
    logic [7:0]             res_cmd;
    logic [31:0]            res_word;
    logic                   res_ok;
    logic [2:0]             pos;
    logic [BYTE_IDX_W-1:0]  idx;
    logic [7:0]             shifted;

    assign q_pop        = q_valid && (!out_valid_reg || !out_stall);
    assign pos          = count_reg[2:0];
    assign idx          = count_reg[COUNT_W-1:3];
    assign shifted      = {q_data.one_ok, shift_reg[7:1]};

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign command_byte = cmd_out_reg;
    assign first_word   = word_out_reg;
    assign checksum_ok  = ok_out_reg;

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        shift_next  = shift_reg;
        sum_next    = sum_reg;
        word_next   = word_reg;
        cmd_next    = cmd_reg;
        emit        = 1'b0;
        res_status  = STATUS_OK;
        res_cmd     = '0;
        res_word    = '0;
        res_ok      = 1'b0;
        if (q_pop)
        begin
            priority if (q_data.frame_start)
            begin
                active_next = 1'b1;
                count_next  = '0;
                shift_next  = '0;
                sum_next    = '0;
                word_next   = '0;
                cmd_next    = '0;
                if (!q_data.header_ok)
                begin
                    emit       = 1'b1;
                    res_status = STATUS_BAD_HEADER;
                end
                else if (q_data.frame_end)
                begin
                    emit       = 1'b1;
                    res_status = STATUS_SHORT;
                end
            end
            else if (active_reg)
            begin
                priority if (!q_data.bit_mark_ok)
                begin
                    emit       = 1'b1;
                    res_status = STATUS_BAD_MARK;
                end
                else if (!q_data.one_ok && !q_data.zero_ok)
                begin
                    emit       = 1'b1;
                    res_status = STATUS_BAD_SPACE;
                end
                else
                begin
                    shift_next = shifted;
                    count_next = count_reg + 1'b1;
                    if (pos == 3'd7 && idx == LAST_IDX)
                    begin
                        emit       = 1'b1;
                        res_status = STATUS_OK;
                        res_cmd    = cmd_reg;
                        res_word   = word_reg;
                        res_ok     = (sum_reg == shifted);
                    end
                    else
                    begin
                        if (pos == 3'd7)
                        begin
                            if (idx < WORD_END)
                            begin
                                word_next[{idx[1:0], 3'b000} +: 8] = shifted;
                            end
                            if (idx == CMD_IDX)
                            begin
                                cmd_next = shifted;
                            end
                            sum_next   = sum_reg + shifted;
                            shift_next = '0;
                        end
                        if (q_data.frame_end)
                        begin
                            emit       = 1'b1;
                            res_status = STATUS_SHORT;
                        end
                    end
                end
            end
            else
            begin
                active_next = active_reg;
            end
        end
        if (emit)
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            count_reg     <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            word_reg      <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            sum_reg       <= sum_next;
            word_reg      <= word_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg   <= res_status;
            cmd_out_reg  <= res_cmd;
            word_out_reg <= res_word;
            ok_out_reg   <= res_ok;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ir_ac_frame_decoder_top.sv
// Infrared air-conditioner frame decoder.
// Input channel (in_valid / in_stall): one word per infrared symbol, carrying the
// measured mark and space durations and the frame start and end flags. A word is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): at most one result word per frame,
// given when the frame completes or ends early, or at its first timing failure:
// status, command byte, the first four bytes and the checksum flag.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): expected
// durations and tolerance; cfg_ready is always high. Write only while idle.
// Throughput: one symbol per cycle, sustained while out_stall is low. Each symbol
// is held in the input stage, where its durations are classified, and then in
// the two-entry queue; the decoder stage takes the queue head and loads its
// output register at the same edge.
// Reset loads the default durations and tolerance and leaves the decoder idle,
// waiting for a header symbol.
// While out_stall is high a valid result is held; the decoder stops, the queue fills
// and then in_stall rises, so no word is lost.
`default_nettype none

module ir_ac_frame_decoder_top
#(
    parameter int unsigned FRAME_BYTES = irfd_pkg::FRAME_BYTES_DEFAULT
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [irfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [irfd_pkg::TICK_W-1:0]          cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [irfd_pkg::TICK_W-1:0]          mark_ticks,
    input  wire logic [irfd_pkg::TICK_W-1:0]          space_ticks,
    input  wire logic                                 frame_start,
    input  wire logic                                 frame_end,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output irfd_pkg::status_t                         status,
    output logic [7:0]                                command_byte,
    output logic [31:0]                               first_word,
    output logic                                      checksum_ok
);
    import irfd_pkg::*;

    logic           q_push, q_ready, q_pop, q_valid;
    symbol_class_t  q_in, q_out;

    irfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mark_ticks  (mark_ticks),
        .space_ticks (space_ticks),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    irfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out)
    );

    irfd_back
    #(
        .FRAME_BYTES (FRAME_BYTES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .command_byte (command_byte),
        .first_word   (first_word),
        .checksum_ok  (checksum_ok)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import irfd_pkg::*;

    localparam int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT;
    localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int PIPE_SETTLE  = 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 250;
    localparam int PHASE_FRAMES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TICK_W-1:0] mark;
        logic [TICK_W-1:0] space;
        logic              start;
        logic              last;
    } symbol_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  cmd;
        logic [31:0] word;
        logic        sum_ok;
    } report_t;

    typedef enum int {
        FR_FULL,
        FR_TRUNCATED,
        FR_BAD_BIT,
        FR_BAD_HEADER,
        FR_RESTART,
        FR_NOISE
    } frame_kind_t;

    typedef enum int {
        SET_RANDOM,
        SET_WIDE,
        SET_EXACT
    } setting_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [TICK_W-1:0]      mark_ticks = '0;
    logic [TICK_W-1:0]      space_ticks = '0;
    logic                   frame_start = 1'b0;
    logic                   frame_end = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    status_t                status;
    logic [7:0]             command_byte;
    logic [31:0]            first_word;
    logic                   checksum_ok;

    // decoder model: settings and frame state
    logic [TICK_W-1:0] hdr_mark   = TICK_W'(HEADER_MARK_RST);
    logic [TICK_W-1:0] hdr_space  = TICK_W'(HEADER_SPACE_RST);
    logic [TICK_W-1:0] bit_mark   = TICK_W'(BIT_MARK_RST);
    logic [TICK_W-1:0] one_space  = TICK_W'(ONE_SPACE_RST);
    logic [TICK_W-1:0] zero_space = TICK_W'(ZERO_SPACE_RST);
    logic [TOL_W-1:0]  tol_pct    = TOL_W'(TOL_RST);
    logic [7:0]        bit_count  = '0;
    logic [7:0]        shift_byte = '0;
    logic [7:0]        byte_sum   = '0;
    logic [7:0]        cmd_byte   = '0;
    logic [31:0]       word_bytes = '0;
    logic              frame_open = 1'b0;

    symbol_t symbol_queue[$];
    report_t pending_reports[$];

    bit in_fire = 1'b0;
    bit cfg_fire = 1'b0;
    int items_pushed = 0;
    int items_taken = 0;
    int phase_items = 0;
    int phase_frames = 0;
    int reports_checked = 0;
    int mismatches = 0;
    int sum_good = 0;
    int status_count [5] = '{0, 0, 0, 0, 0};
    int cycle_count = 0;
    int send_gap = 0;
    int send_quiet = 0;
    int hold_left = 0;
    int recv_quiet = 0;

    ir_ac_frame_decoder_top #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mark_ticks   (mark_ticks),
        .space_ticks  (space_ticks),
        .frame_start  (frame_start),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .command_byte (command_byte),
        .first_word   (first_word),
        .checksum_ok  (checksum_ok)
    );

    always #10 clk = ~clk;

    function automatic bit in_window(logic [TICK_W-1:0] got, logic [TICK_W-1:0] want);
        longint unsigned diff;
        diff = (got > want) ? 64'(got - want) : 64'(want - got);
        return diff * 64'd100 <= 64'(want) * 64'(tol_pct);
    endfunction

    function automatic logic [TICK_W-1:0] window_edge(logic [TICK_W-1:0] want, bit upper);
        longint unsigned span;
        span = (64'(want) * 64'(tol_pct)) / 64'd100;
        if (upper)
            return (64'(want) + span > 64'(TICK_MAX)) ? TICK_MAX : TICK_W'(64'(want) + span);
        return (64'(want) > span) ? TICK_W'(64'(want) - span) : '0;
    endfunction

    function automatic logic [TICK_W-1:0] pick_near(logic [TICK_W-1:0] want);
        logic [TICK_W-1:0] lo;
        logic [TICK_W-1:0] hi;
        lo = window_edge(want, 1'b0);
        hi = window_edge(want, 1'b1);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return TICK_W'($urandom_range(32'(hi), 32'(lo)));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_far(logic [TICK_W-1:0] want);
        logic [TICK_W-1:0] lo;
        logic [TICK_W-1:0] hi;
        bit above_ok;
        bit below_ok;
        lo = window_edge(want, 1'b0);
        hi = window_edge(want, 1'b1);
        above_ok = hi != TICK_MAX;
        below_ok = lo != 0;
        if (above_ok && (!below_ok || $urandom_range(0, 1) == 1)) begin
            if ($urandom_range(0, 3) == 0)
                return hi + 1'b1;
            return TICK_W'($urandom_range(32'(TICK_MAX), 32'(hi) + 1));
        end
        if (below_ok) begin
            if ($urandom_range(0, 3) == 0)
                return lo - 1'b1;
            return TICK_W'($urandom_range(32'(lo) - 1, 0));
        end
        return TICK_W'($urandom);
    endfunction

    // space that decodes as neither a one nor a zero, where the windows leave room
    function automatic logic [TICK_W-1:0] pick_bad_space();
        logic [TICK_W-1:0] v;
        v = pick_far(one_space);
        for (int i = 0; i < 8 && in_window(v, zero_space); i++)
            v = pick_far(one_space);
        return v;
    endfunction

    function automatic int draw_idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 99) < 2) begin
            quiet = $urandom_range(40, 200);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void post_report(status_t st, logic [7:0] cmd, logic [31:0] word,
                                        logic ok);
        report_t r;
        r.status = st;
        r.cmd = cmd;
        r.word = word;
        r.sum_ok = ok;
        pending_reports.push_back(r);
        frame_open = 1'b0;
    endfunction

    function automatic void decode_symbol(symbol_t s);
        logic       bit_val;
        logic [2:0] pos;
        logic [4:0] idx;
        if (s.start) begin
            bit_count = '0;
            shift_byte = '0;
            byte_sum = '0;
            word_bytes = '0;
            cmd_byte = '0;
            frame_open = 1'b1;
            if (!in_window(s.mark, hdr_mark) || !in_window(s.space, hdr_space))
                post_report(STATUS_BAD_HEADER, '0, '0, 1'b0);
            else if (s.last)
                post_report(STATUS_SHORT, '0, '0, 1'b0);
            return;
        end
        if (!frame_open)
            return;
        if (!in_window(s.mark, bit_mark)) begin
            post_report(STATUS_BAD_MARK, '0, '0, 1'b0);
            return;
        end
        if (in_window(s.space, one_space))
            bit_val = 1'b1;
        else if (in_window(s.space, zero_space))
            bit_val = 1'b0;
        else begin
            post_report(STATUS_BAD_SPACE, '0, '0, 1'b0);
            return;
        end
        pos = bit_count[2:0];
        idx = bit_count[7:3];
        shift_byte = {bit_val, shift_byte[7:1]};
        bit_count = bit_count + 8'd1;
        if (pos == 3'd7) begin
            if (32'(idx) == FRAME_BYTES - 1) begin
                post_report(STATUS_OK, cmd_byte, word_bytes, byte_sum == shift_byte);
                return;
            end
            if (32'(idx) < WORD_BYTES)
                word_bytes[8*idx +: 8] = shift_byte;
            if (32'(idx) == CMD_BYTE_IDX)
                cmd_byte = shift_byte;
            byte_sum = byte_sum + shift_byte;
            shift_byte = '0;
        end
        if (s.last)
            post_report(STATUS_SHORT, '0, '0, 1'b0);
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] reg_index,
                                           logic [TICK_W-1:0] data);
        case (reg_index)
            REG_HEADER_MARK:  hdr_mark = data;
            REG_HEADER_SPACE: hdr_space = data;
            REG_BIT_MARK:     bit_mark = data;
            REG_ONE_SPACE:    one_space = data;
            REG_ZERO_SPACE:   zero_space = data;
            REG_TOLERANCE:    tol_pct = data[TOL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void queue_symbol(logic [TICK_W-1:0] mark, logic [TICK_W-1:0] space,
                                         logic start, logic last, bit counted);
        symbol_t s;
        s.mark = mark;
        s.space = space;
        s.start = start;
        s.last = last;
        symbol_queue.push_back(s);
        items_pushed++;
        if (counted)
            phase_items++;
    endfunction

    function automatic void queue_header(logic last);
        queue_symbol(pick_near(hdr_mark), pick_near(hdr_space), 1'b1, last, 1'b1);
    endfunction

    function automatic void queue_bits(logic [7:0] frame_bytes [FRAME_BYTES], int nbits,
                                       bit end_flag);
        logic b;
        for (int i = 0; i < nbits; i++) begin
            b = frame_bytes[i / 8][i % 8];
            queue_symbol(pick_near(bit_mark), b ? pick_near(one_space) : pick_near(zero_space),
                         1'b0, end_flag && i == nbits - 1, 1'b1);
        end
    endfunction

    function automatic void queue_frame(frame_kind_t kind);
        logic [7:0] frame_bytes [FRAME_BYTES];
        logic [7:0] sum;
        int         nbits;
        bit         end_flag;
        sum = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_bytes[i] = 8'($urandom);
            if (i < FRAME_BYTES - 1)
                sum = sum + frame_bytes[i];
        end
        if ($urandom_range(0, 1) == 1)
            frame_bytes[FRAME_BYTES-1] = sum;
        nbits = ($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_BITS - 1)
                                             : $urandom_range(0, 15);
        end_flag = 1'($urandom_range(0, 1));
        case (kind)
            FR_FULL: begin
                queue_header(1'b0);
                queue_bits(frame_bytes, FRAME_BITS, end_flag);
                // trailing symbols after a complete frame
                repeat ($urandom_range(0, 2))
                    queue_symbol(pick_near(bit_mark), pick_near(zero_space), 1'b0,
                                 1'($urandom_range(0, 1)), 1'b0);
                phase_frames++;
            end
            FR_TRUNCATED: begin
                queue_header(nbits == 0);
                queue_bits(frame_bytes, nbits, 1'b1);
                phase_frames++;
            end
            FR_BAD_BIT: begin
                queue_header(1'b0);
                queue_bits(frame_bytes, nbits, 1'b0);
                if ($urandom_range(0, 1) == 1)
                    queue_symbol(pick_far(bit_mark), pick_near(one_space), 1'b0, end_flag, 1'b1);
                else
                    queue_symbol(pick_near(bit_mark), pick_bad_space(), 1'b0, end_flag, 1'b1);
                phase_frames++;
            end
            FR_BAD_HEADER: begin
                case ($urandom_range(0, 2))
                    0: queue_symbol(pick_far(hdr_mark), pick_near(hdr_space), 1'b1, end_flag, 1'b1);
                    1: queue_symbol(pick_near(hdr_mark), pick_far(hdr_space), 1'b1, end_flag, 1'b1);
                    default:
                        queue_symbol(pick_far(hdr_mark), pick_far(hdr_space), 1'b1, end_flag, 1'b1);
                endcase
                repeat ($urandom_range(0, 2))
                    queue_symbol(pick_near(bit_mark), pick_near(one_space), 1'b0, 1'b0, 1'b0);
                phase_frames++;
            end
            FR_RESTART: begin
                queue_header(1'b0);
                queue_bits(frame_bytes, nbits, 1'b0);
            end
            default: begin
                repeat ($urandom_range(1, 4))
                    queue_symbol(TICK_W'($urandom), TICK_W'($urandom), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'b0);
            end
        endcase
    endfunction

    task automatic wait_idle();
        while (items_taken != items_pushed || pending_reports.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] reg_index, logic [TICK_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= data;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(setting_t setting);
        case (setting)
            SET_RANDOM: begin
                write_reg(REG_HEADER_MARK, TICK_W'($urandom_range(1000, 30000)));
                write_reg(REG_HEADER_SPACE, TICK_W'($urandom_range(500, 20000)));
                write_reg(REG_BIT_MARK, TICK_W'($urandom_range(50, 5000)));
                write_reg(REG_ONE_SPACE, TICK_W'($urandom_range(1000, 10000)));
                write_reg(REG_ZERO_SPACE, TICK_W'($urandom_range(50, 900)));
                write_reg(REG_TOLERANCE, TICK_W'($urandom_range(0, 60)));
                // indexes past the register list must leave everything alone
                write_reg(REG_SPARE_FIRST, TICK_W'($urandom));
                write_reg(REG_SPARE_LAST, TICK_W'($urandom));
            end
            SET_WIDE: begin
                write_reg(REG_HEADER_MARK, TICK_MAX);
                write_reg(REG_HEADER_SPACE, TICK_MAX);
                write_reg(REG_BIT_MARK, TICK_MAX);
                write_reg(REG_ONE_SPACE, TICK_MAX);
                write_reg(REG_ZERO_SPACE, '0);
                write_reg(REG_TOLERANCE, TICK_MAX);
            end
            default: begin
                write_reg(REG_HEADER_MARK, '0);
                write_reg(REG_HEADER_SPACE, TICK_MAX);
                write_reg(REG_BIT_MARK, TICK_W'(1));
                write_reg(REG_ONE_SPACE, TICK_MAX);
                write_reg(REG_ZERO_SPACE, '0);
                write_reg(REG_TOLERANCE, '0);
            end
        endcase
    endtask

    function automatic void queue_directed();
        queue_symbol(TICK_MAX, TICK_MAX, 1'b0, 1'b0, 1'b1);
        queue_symbol('0, '0, 1'b1, 1'b0, 1'b1);
        queue_symbol(window_edge(hdr_mark, 1'b1), hdr_space, 1'b1, 1'b1, 1'b1);
        queue_symbol(window_edge(hdr_mark, 1'b1) + 1'b1, hdr_space, 1'b1, 1'b1, 1'b1);
        queue_symbol(hdr_mark, window_edge(hdr_space, 1'b0), 1'b1, 1'b0, 1'b1);
        queue_symbol('0, one_space, 1'b0, 1'b0, 1'b1);
        queue_symbol(TICK_MAX, TICK_MAX, 1'b0, 1'b1, 1'b1);
        queue_symbol(hdr_mark, hdr_space, 1'b1, 1'b0, 1'b1);
        queue_symbol(bit_mark, one_space, 1'b0, 1'b0, 1'b1);
        queue_symbol(bit_mark, TICK_MAX, 1'b0, 1'b0, 1'b1);
        queue_symbol(hdr_mark, hdr_space, 1'b1, 1'b0, 1'b1);
        queue_symbol(bit_mark, zero_space, 1'b0, 1'b0, 1'b1);
        queue_symbol(hdr_mark, hdr_space, 1'b1, 1'b0, 1'b1);
        queue_symbol(window_edge(bit_mark, 1'b0), window_edge(one_space, 1'b1),
                     1'b0, 1'b1, 1'b1);
        queue_symbol(TICK_MAX, '0, 1'b1, 1'b1, 1'b1);
        queue_symbol(window_edge(hdr_mark, 1'b0), window_edge(hdr_space, 1'b1),
                     1'b1, 1'b0, 1'b1);
        queue_symbol(window_edge(bit_mark, 1'b1) + 1'b1, zero_space, 1'b0, 1'b0, 1'b1);
    endfunction

    task automatic run_random_phase();
        int pick;
        bit paused;
        phase_items = 0;
        phase_frames = 0;
        paused = 1'b0;
        while (phase_items < PHASE_ITEMS || phase_frames < PHASE_FRAMES) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                queue_frame(FR_FULL);
            else if (pick < 37)
                queue_frame(FR_TRUNCATED);
            else if (pick < 62)
                queue_frame(FR_BAD_BIT);
            else if (pick < 77)
                queue_frame(FR_BAD_HEADER);
            else if (pick < 90)
                queue_frame(FR_RESTART);
            else
                queue_frame(FR_NOISE);
            // sender holds off until the decoder has drained
            if (!paused && phase_items >= PHASE_ITEMS / 2) begin
                wait_idle();
                paused = 1'b1;
            end
        end
    endtask

    // symbol sender
    always @(negedge clk) begin
        symbol_t s;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (symbol_queue.size() != 0) begin
                s = symbol_queue.pop_front();
                mark_ticks <= s.mark;
                space_ticks <= s.space;
                frame_start <= s.start;
                frame_end <= s.last;
                in_valid <= 1'b1;
                send_gap = draw_idle_len(send_quiet);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver back-pressure
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else begin
            out_stall <= 1'b0;
            hold_left = draw_idle_len(recv_quiet);
        end
    end

    always @(posedge clk) begin
        symbol_t s;
        report_t got;
        report_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
        else begin
            in_fire = rst_n && in_valid && !in_stall;
            cfg_fire = rst_n && cfg_valid && cfg_ready;
            if (cfg_fire)
                apply_register(cfg_index, cfg_data);
            if (in_fire) begin
                s.mark = mark_ticks;
                s.space = space_ticks;
                s.start = frame_start;
                s.last = frame_end;
                decode_symbol(s);
                items_taken++;
            end
            if (rst_n && out_valid && !out_stall) begin
                got.status = status;
                got.cmd = command_byte;
                got.word = first_word;
                got.sum_ok = checksum_ok;
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: status %0d cmd %02h word %08h sum_ok %0b",
                                 got.status, got.cmd, got.word, got.sum_ok);
                end
                else begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    status_count[int'(want.status)]++;
                    if (want.status == STATUS_OK && want.sum_ok)
                        sum_good++;
                    if (got.status !== want.status || got.cmd !== want.cmd
                            || got.word !== want.word || got.sum_ok !== want.sum_ok) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result %0d: expected status %0d cmd %02h word %08h sum_ok %0b, got status %0d cmd %02h word %08h sum_ok %0b",
                                     reports_checked, want.status, want.cmd, want.word,
                                     want.sum_ok, got.status, got.cmd, got.word, got.sum_ok);
                    end
                end
            end
        end
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        queue_directed();
        run_random_phase();
        wait_idle();
        load_settings(SET_RANDOM);
        run_random_phase();
        wait_idle();
        load_settings(SET_WIDE);
        run_random_phase();
        wait_idle();
        load_settings(SET_EXACT);
        run_random_phase();
        wait_idle();
        $display("%0d symbols decoded into %0d results under default, random, widest and exact timing windows",
                 items_taken, reports_checked);
        $display("ok %0d (checksum good %0d), bad header %0d, bad mark %0d, bad space %0d, short %0d",
                 status_count[0], sum_good, status_count[1], status_count[2], status_count[3],
                 status_count[4]);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
